### rtl/vwna_pkg.sv
// Package for the volume weighted node average unit: request codes, states, payload types.
package vwna_pkg;

    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_ACC    = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_ACC_RD,
        ST_ACC_WR,
        ST_RD_RD,
        ST_RD_CHK,
        ST_DIV,
        ST_SQ,
        ST_SQRT
    } t_state;

    typedef struct packed {
        logic        [1:0]  req_type;
        logic        [2:0]  vertex_count;
        logic        [11:0] node_a;
        logic        [11:0] node_b;
        logic        [11:0] node_c;
        logic        [11:0] node_d;
        logic        [23:0] volume;
        logic signed [31:0] field_x;
        logic signed [31:0] field_y;
        logic signed [31:0] field_z;
        logic        [11:0] read_node;
    } t_in;

    typedef struct packed {
        logic signed [31:0] avg_x;
        logic signed [31:0] avg_y;
        logic signed [31:0] avg_z;
        logic        [31:0] magnitude;
        logic               covered;
    } t_out;

    typedef struct packed {
        logic signed [63:0] sx;
        logic signed [63:0] sy;
        logic signed [63:0] sz;
        logic        [39:0] w;
    } t_rec;

endpackage

### rtl/vwna_div.sv
// Iterative restoring divider, 64-bit dividend by 40-bit divisor, one quotient bit per cycle.
module vwna_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [39:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quot
);
    logic        r_run;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_dvd;
    logic [40:0] r_rem;
    logic [39:0] r_dsr;
    logic [40:0] rem_s;
    logic        ge;

    assign rem_s = {r_rem[39:0], r_dvd[63]};
    assign ge    = rem_s >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && r_cnt == 6'd63) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
            r_cnt <= '0;
        end else if (r_run) begin
            r_rem <= ge ? (rem_s - {1'b0, r_dsr}) : rem_s;
            r_dvd <= {r_dvd[62:0], ge};
            r_cnt <= r_cnt + 6'd1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dvd;
endmodule

### rtl/volume_weighted_node_average_unit.sv
// Top level of the volume weighted node average unit.
//
// Requests transfer on start & !busy. Clear empties the node table by sweeping
// every entry of the touched memory; the same sweep runs after reset, busy high.
// Accumulate handles each used vertex with a memory read, then an add and write
// back; a vertex whose node lies outside the table is skipped.
// Read does the memory read, then the weight check; an uncovered node returns
// zeros in the cycle after the check. A covered node runs three divisions on
// one shared divider, then squaring and a square root, with the result in the
// cycle after the last square-root step. A result is shown for one cycle with
// o_valid; the receiver cannot stall it. The user must write min_weight through
// i_cfg_we / i_cfg_wdata only while the unit is idle; the unit does not enforce it.
module volume_weighted_node_average_unit #(
    parameter int NODES        = 4096,
    parameter int MAX_VERTICES = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  vwna_pkg::t_in       i_req,
    output logic                busy,
    input  logic                i_cfg_we,
    input  logic [39:0]         i_cfg_wdata,
    output logic                o_valid,
    output vwna_pkg::t_out      o_result
);
    import vwna_pkg::*;

    localparam int AW = $clog2(NODES);
    localparam int EW = AW + 12;

    t_rec        mem  [NODES];
    logic        tmem [NODES];

    t_state      r_state, n_state;
    t_in         r_req;
    logic [39:0] r_min_weight;
    logic [AW-1:0] r_clr;
    logic [AW-1:0] r_waddr;
    logic [2:0]  r_k;
    logic [2:0]  r_cnt;
    logic signed [56:0] r_px, r_py, r_pz;
    t_rec        r_q;
    logic        r_tq;
    logic        r_rvalid;
    logic signed [63:0] r_sum [3];
    logic        r_neg [3];
    logic [39:0] r_w;
    logic [1:0]  r_comp;
    logic signed [31:0] r_avg [3];
    logic [4:0]  r_sc;
    logic [63:0] r_prod, r_acc, r_op, r_res, r_one;
    logic        r_valid;
    t_out        r_out;

    logic [AW-1:0] rd_addr;
    logic        mem_we;
    t_rec        mem_wd;
    logic        tm_we;
    logic        tm_wd;
    logic [AW-1:0] tm_wa;
    logic [11:0] vnode;
    logic [EW-1:0] vext, rext;
    logic        vvalid, rvalid;
    t_rec        old;
    logic [39:0] chk_w;
    logic        chk_cov;
    logic        div_start, div_done;
    logic [63:0] div_dvd, div_quot;
    logic [39:0] div_dsr;
    logic [1:0]  nxt_comp;
    logic signed [31:0] sat_q;
    logic [63:0] sq_t, sq_res_n, sq_op_n;
    logic [40:0] w_sum;
    logic [2:0]  cnt_in;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] s,
                                                   input logic signed [56:0] p);
        logic signed [64:0] t;
        t = {s[63], s} + {{8{p[56]}}, p};
        if (t[64] != t[63]) begin
            return t[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return t[63:0];
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] s);
        return s[63] ? (64'd0 - 64'(s)) : 64'(s);
    endfunction

    always_comb begin
        case (r_k[1:0])
            2'd0:    vnode = r_req.node_a;
            2'd1:    vnode = r_req.node_b;
            2'd2:    vnode = r_req.node_c;
            default: vnode = r_req.node_d;
        endcase
    end

    assign vext   = EW'(vnode);
    assign rext   = EW'(r_req.read_node);
    assign vvalid = vext < EW'(NODES);
    assign rvalid = rext < EW'(NODES);
    assign cnt_in = (i_req.vertex_count > 3'(MAX_VERTICES)) ? 3'(MAX_VERTICES)
                                                            : i_req.vertex_count;

    assign old    = r_tq ? r_q : '0;
    assign w_sum  = {1'b0, old.w} + 41'(r_req.volume);
    assign mem_wd = '{sx: sat_add(old.sx, r_px), sy: sat_add(old.sy, r_py),
                      sz: sat_add(old.sz, r_pz), w: w_sum[40] ? {40{1'b1}} : w_sum[39:0]};

    assign chk_w   = (r_rvalid && r_tq) ? r_q.w : 40'd0;
    assign chk_cov = chk_w > r_min_weight;

    assign nxt_comp = r_comp + 2'd1;
    assign div_dvd  = (r_state == ST_RD_CHK) ? mag64(r_q.sx) : mag64(r_sum[nxt_comp]);
    assign div_dsr  = (r_state == ST_RD_CHK) ? chk_w : r_w;

    always_comb begin
        if (r_neg[r_comp]) begin
            sat_q = (div_quot > 64'h8000_0000) ? 32'sh8000_0000 : 32'(64'd0 - div_quot);
        end else begin
            sat_q = (div_quot > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(div_quot);
        end
    end

    assign sq_t = r_res + r_one;
    always_comb begin
        if (r_op >= sq_t) begin
            sq_op_n  = r_op - sq_t;
            sq_res_n = (r_res >> 1) + r_one;
        end else begin
            sq_op_n  = r_op;
            sq_res_n = r_res >> 1;
        end
    end

    vwna_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dsr),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        rd_addr   = r_waddr;
        mem_we    = 1'b0;
        tm_we     = 1'b0;
        tm_wd     = 1'b0;
        tm_wa     = r_waddr;
        div_start = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    case (i_req.req_type)
                        REQ_CLEAR: n_state = ST_CLEAR;
                        REQ_ACC:   n_state = ST_ACC_RD;
                        REQ_READ:  n_state = ST_RD_RD;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR: begin
                tm_we = 1'b1;
                tm_wa = r_clr;
                if (r_clr == AW'(NODES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_ACC_RD: begin
                rd_addr = vext[AW-1:0];
                if (r_k >= r_cnt) begin
                    n_state = ST_IDLE;
                end else if (vvalid) begin
                    n_state = ST_ACC_WR;
                end
            end
            ST_ACC_WR: begin
                mem_we  = 1'b1;
                tm_we   = 1'b1;
                tm_wd   = 1'b1;
                n_state = ST_ACC_RD;
            end
            ST_RD_RD: begin
                rd_addr = rext[AW-1:0];
                n_state = ST_RD_CHK;
            end
            ST_RD_CHK: begin
                if (chk_cov) begin
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    if (r_comp == 2'd2) begin
                        n_state = ST_SQ;
                    end else begin
                        div_start = 1'b1;
                    end
                end
            end
            ST_SQ: begin
                if (r_sc == 5'd3) begin
                    n_state = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (r_sc == 5'd31) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // node record and touched memories
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_waddr] <= mem_wd;
        end
        r_q <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (tm_we) begin
            tmem[tm_wa] <= tm_wd;
        end
        r_tq <= tmem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_weight <= '0;
            r_clr        <= '0;
            r_valid      <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                r_min_weight <= i_cfg_wdata;
            end
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end else if (r_state == ST_IDLE) begin
                r_clr <= '0;
            end
            if (r_state == ST_RD_CHK && !chk_cov) begin
                r_valid <= 1'b1;
            end
            if (r_state == ST_SQRT && r_sc == 5'd31) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    r_req <= i_req;
                    r_k   <= '0;
                    r_cnt <= cnt_in;
                    r_px  <= $signed({1'b0, i_req.volume}) * i_req.field_x;
                    r_py  <= $signed({1'b0, i_req.volume}) * i_req.field_y;
                    r_pz  <= $signed({1'b0, i_req.volume}) * i_req.field_z;
                end
            end
            ST_ACC_RD: begin
                if (r_k < r_cnt) begin
                    r_waddr <= vext[AW-1:0];
                    r_k     <= r_k + 3'd1;
                end
            end
            ST_RD_RD: begin
                r_rvalid <= rvalid;
            end
            ST_RD_CHK: begin
                r_sum[0] <= r_q.sx;
                r_sum[1] <= r_q.sy;
                r_sum[2] <= r_q.sz;
                r_neg[0] <= r_q.sx[63];
                r_neg[1] <= r_q.sy[63];
                r_neg[2] <= r_q.sz[63];
                r_w      <= chk_w;
                r_comp   <= '0;
                r_out    <= '0;
            end
            ST_DIV: begin
                if (div_done) begin
                    r_avg[r_comp] <= sat_q;
                    r_comp        <= nxt_comp;
                    r_sc          <= '0;
                end
            end
            ST_SQ: begin
                if (r_sc != 5'd3) begin
                    r_prod <= 64'(r_avg[r_sc[1:0]] * r_avg[r_sc[1:0]]);
                end
                r_acc <= (r_sc == 5'd0) ? 64'd0 : r_acc + r_prod;
                if (r_sc == 5'd3) begin
                    r_op  <= r_acc + r_prod;
                    r_res <= '0;
                    r_one <= 64'd1 << 62;
                    r_sc  <= '0;
                end else begin
                    r_sc <= r_sc + 5'd1;
                end
            end
            ST_SQRT: begin
                r_op  <= sq_op_n;
                r_res <= sq_res_n;
                r_one <= r_one >> 2;
                r_sc  <= r_sc + 5'd1;
                if (r_sc == 5'd31) begin
                    r_out <= '{avg_x: r_avg[0], avg_y: r_avg[1], avg_z: r_avg[2],
                               magnitude: sq_res_n[31:0], covered: 1'b1};
                end
            end
            default: begin
            end
        endcase
    end

    assign busy     = r_state != ST_IDLE;
    assign o_valid  = r_valid;
    assign o_result = r_out;

    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without a request in flight");

    a_uncovered_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.covered) |->
            (o_result.avg_x == 0 && o_result.avg_y == 0 && o_result.avg_z == 0 &&
             o_result.magnitude == 0))
        else $error("uncovered node with nonzero result");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_valid)
        else $error("result during table clear");
endmodule
